[hdl/spp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants for the saturating progress percentage block.
// ----------------------------------------------------------------------------
package spp_pkg;

   localparam int unsigned AMOUNT_W  = 32;
   localparam int unsigned PRODUCT_W = 40;
   localparam int unsigned DIVISOR_W = 38;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned RSP_W     = 24;

   // full scale, also fed through the digit shifter when progress is saturated
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [2:0]       QUOT_MSB = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE_HI,
      ST_SCALE_LO,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

[hdl/saturating_progress_percent.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_progress_percent
// Saturating progress counter with whole-percent and decimal digit output.
// ----------------------------------------------------------------------------
// Each request transfer adds its amount to the progress total, clamped at the
// limit held in the csr register; a csr write sets a new limit and clears the
// progress. Every request gives one response: the whole percentage
// total*100/limit (100 once the limit is reached, including a zero limit),
// its hundreds, tens and ones digits with blank flags for leading zeros, and
// a saturated flag. The response goes valid once the request has passed
// through the states in order: the clamped add happens in the transfer cycle
// itself, then ST_SCALE_HI and ST_SCALE_LO form total*100 by shift and add,
// a restoring divider in ST_DIVIDE produces one quotient bit per cycle and
// shifts it straight into a BCD digit register, and ST_DONE loads the response
// register. The next request is taken only after that, back in ST_IDLE. The
// response register frees the block, so the next request is taken while a
// result still waits for rsp_tready; the following result then waits in the
// block until that response transfer.
// ----------------------------------------------------------------------------
module saturating_progress_percent (
   input  logic        clock,
   input  logic        reset,
   // limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,     // progress_limit
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // step_amount
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // percent[6:0], hundreds_digit[7], tens_digit[11:8], ones_digit[15:12],
   // hundreds_blank[16], tens_blank[17], saturated[18], zero[23:19]
   output logic [23:0] rsp_tdata
);

   localparam int unsigned AW = spp_pkg::AMOUNT_W;
   localparam int unsigned PW = spp_pkg::PRODUCT_W;
   localparam int unsigned DW = spp_pkg::DIVISOR_W;
   localparam int unsigned QW = spp_pkg::PCT_W;
   localparam int unsigned GW = spp_pkg::DIGIT_W;

   spp_pkg::state_type state_ff, state_in;

   logic [AW-1:0] limit_ff, limit_in;
   logic [AW-1:0] total_ff, total_in;
   logic          sat_ff, sat_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [QW-1:0] pct_ff, pct_in;
   logic          hun_ff, hun_in;
   logic [GW-1:0] ten_ff, ten_in;
   logic [GW-1:0] one_ff, one_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [spp_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [AW:0]   sum;
   logic          q_bit;
   logic [GW-1:0] ten_adj, one_adj;
   logic          req_xfer, csr_xfer;

   assign csr_ready  = (state_ff == spp_pkg::ST_IDLE);
   assign req_tready = (state_ff == spp_pkg::ST_IDLE) && !csr_valid;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sum = {1'b0, total_ff} + {1'b0, req_tdata};

   // saturated results shift the constant full scale through the digit path
   assign q_bit = sat_ff ? spp_pkg::PCT_FULL[cnt_ff]
                         : (rem_ff >= {{(PW-DW){1'b0}}, div_ff});

   // double dabble correction before each shift
   assign ten_adj = (ten_ff >= 4'd5) ? ten_ff + 4'd3 : ten_ff;
   assign one_adj = (one_ff >= 4'd5) ? one_ff + 4'd3 : one_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spp_pkg::ST_IDLE;
         limit_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      pct_ff      <= pct_in;
      hun_ff      <= hun_in;
      ten_ff      <= ten_in;
      one_ff      <= one_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      pct_in       = pct_ff;
      hun_in       = hun_ff;
      ten_in       = ten_ff;
      one_in       = one_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         spp_pkg::ST_IDLE: begin
            if (csr_xfer) begin
               limit_in = csr_data;
               total_in = '0;
            end else if (req_xfer) begin
               if (sum >= {1'b0, limit_ff}) begin
                  total_in = limit_ff;
                  sat_in   = 1'b1;
               end else begin
                  total_in = sum[AW-1:0];
                  sat_in   = 1'b0;
               end
               state_in = spp_pkg::ST_SCALE_HI;
            end
         end
         spp_pkg::ST_SCALE_HI: begin
            // total*96 now, total*4 next cycle
            rem_in   = {2'b00, total_ff, 6'b000000} + {3'b000, total_ff, 5'b00000};
            div_in   = {limit_ff, 6'b000000};
            cnt_in   = spp_pkg::QUOT_MSB;
            pct_in   = '0;
            hun_in   = 1'b0;
            ten_in   = '0;
            one_in   = '0;
            state_in = spp_pkg::ST_SCALE_LO;
         end
         spp_pkg::ST_SCALE_LO: begin
            rem_in   = rem_ff + {6'b000000, total_ff, 2'b00};
            state_in = spp_pkg::ST_DIVIDE;
         end
         spp_pkg::ST_DIVIDE: begin
            if (q_bit && !sat_ff) begin
               rem_in = rem_ff - {{(PW-DW){1'b0}}, div_ff};
            end
            div_in = {1'b0, div_ff[DW-1:1]};
            pct_in = {pct_ff[QW-2:0], q_bit};
            hun_in = ten_adj[GW-1];
            ten_in = {ten_adj[GW-2:0], one_adj[GW-1]};
            one_in = {one_adj[GW-2:0], q_bit};
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               state_in = spp_pkg::ST_DONE;
            end
         end
         spp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b00000, sat_ff, (!hun_ff && ten_ff == 4'd0), !hun_ff,
                               one_ff, ten_ff, hun_ff, pct_ff};
               state_in     = spp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spp_pkg::ST_IDLE;
         end
      endcase
   end

   // progress never passes the limit
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= limit_ff)
      else $error("progress total above limit");

   // a request transfer starts the scaling pass
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == spp_pkg::ST_SCALE_HI)
      else $error("request transfer did not start scaling");

   // digits agree with the binary percentage
   a_digits_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({6'b000000, rsp_data_ff[7]} * 7'd100
                        + {3'b000, rsp_data_ff[11:8]} * 7'd10
                        + {3'b000, rsp_data_ff[15:12]}) == rsp_data_ff[6:0])
      else $error("decimal digits disagree with percent");

   // a saturated response reports full scale
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[18] |-> rsp_data_ff[6:0] == spp_pkg::PCT_FULL)
      else $error("saturated response below full scale");

endmodule
